[rtl/ecpg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables of the epicycle chain point generator.
package ecpg_pkg;

    localparam int ARMS      = 3;                // arms in the chain (1..4)
    localparam int CFG_ARMS  = 3;                // arms that own registers
    localparam int CFG_REGS  = 2 * CFG_ARMS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int CNT_W     = 2;                // counts 0..ARMS-1

    localparam int LEN_W   = 16;
    localparam int RATE_W  = 16;
    localparam int STEP_W  = 16;
    localparam int PHASE_W = 24;
    localparam int POS_W   = 19;
    localparam int TRIG_W  = 31;                 // Q30 magnitude, up to 1.0
    localparam int SUM_W   = 50;                 // signed Q46 accumulator

    localparam int NUM_DIVS = 5;
    localparam int ITER_W   = 3;

    // register offsets within one arm's pair
    localparam int REG_LEN_OFS  = 0;
    localparam int REG_RATE_OFS = 1;

    localparam logic [27:0]      PHASE_K    = 28'd170891319;
    localparam logic [31:0]      HALFPI_Q30 = 32'd1686629713;
    localparam logic [30:0]      ONE_Q30    = 31'h4000_0000;
    localparam logic [22:0]      QUARTER    = 23'h40_0000;
    localparam logic [55:0]      PH_ROUND   = 56'h0_0000_8000_0000;
    localparam logic [SUM_W-1:0] POS_ROUND  = SUM_W'(64'h2000_0000);
    localparam int               POS_MAX    = 262143;
    localparam int               POS_MIN_MAG = 262144;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_PH0,
        OP_PH1,
        OP_PH2,
        OP_PH3,
        OP_ANG,
        OP_T_X,
        OP_T_X2,
        OP_T_M,
        OP_T_Q,
        OP_T_C,
        OP_T_S,
        OP_TERM_X,
        OP_TERM_Y,
        OP_SUM
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ITER_W-1:0] iter;
        logic              pass;     // 0: sin(r), 1: sin(quarter - r)
    } t_cmd;

    // Taylor divisors, innermost first
    function automatic logic [6:0] div_const(input logic [ITER_W-1:0] i);
        logic [6:0] d;
        case (i)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] recip_const(input logic [ITER_W-1:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'(64'h1_0000_0000 / 64'd110);
            3'd1:    r = 32'(64'h1_0000_0000 / 64'd72);
            3'd2:    r = 32'(64'h1_0000_0000 / 64'd42);
            3'd3:    r = 32'(64'h1_0000_0000 / 64'd20);
            default: r = 32'(64'h1_0000_0000 / 64'd6);
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] len_reset(input int k);
        logic [LEN_W-1:0] v;
        case (k)
            0:       v = 16'd13107;
            1:       v = 16'd6554;
            2:       v = 16'd6554;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [RATE_W-1:0] rate_reset(input int k);
        logic signed [RATE_W-1:0] v;
        case (k)
            0:       v = 16'sd2048;
            1:       v = 16'sd1024;
            2:       v = -16'sd3072;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ecpg_cell.sv]
`timescale 1ns / 1ps
// One arm of the chain: phase, sine/cosine engine and partial sum stage.
module ecpg_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ecpg_pkg::t_cmd                       i_cmd,
    input  logic [ecpg_pkg::STEP_W-1:0]          i_step,
    input  logic [ecpg_pkg::LEN_W-1:0]           i_len,
    input  logic signed [ecpg_pkg::RATE_W-1:0]   i_rate,
    input  logic [ecpg_pkg::PHASE_W-1:0]         i_angle,
    output logic [ecpg_pkg::PHASE_W-1:0]         o_angle,
    input  logic signed [ecpg_pkg::SUM_W-1:0]    i_sum_x,
    input  logic signed [ecpg_pkg::SUM_W-1:0]    i_sum_y,
    output logic signed [ecpg_pkg::SUM_W-1:0]    o_sum_x,
    output logic signed [ecpg_pkg::SUM_W-1:0]    o_sum_y
);
    import ecpg_pkg::*;

    logic [PHASE_W-1:0]       r_phase;
    logic [PHASE_W-1:0]       r_angle;
    logic [31:0]              r_p;
    logic [43:0]              r_lo;
    logic [43:0]              r_hi;
    logic [31:0]              r_x;
    logic [31:0]              r_x2;
    logic [31:0]              r_m;
    logic [30:0]              r_t;
    logic [29:0]              r_q0;
    logic [TRIG_W-1:0]        r_sin_r;
    logic [TRIG_W-1:0]        r_sin_c;
    logic signed [SUM_W-1:0]  r_tx;
    logic signed [SUM_W-1:0]  r_ty;
    logic signed [SUM_W-1:0]  r_sx;
    logic signed [SUM_W-1:0]  r_sy;

    logic [RATE_W-1:0]  rate_bits;
    logic               rate_neg;
    logic [RATE_W-1:0]  rate_mag;
    logic [22:0]        u;
    logic [TRIG_W-1:0]  cos_mag;
    logic [TRIG_W-1:0]  sin_mag;
    logic               cos_neg;
    logic               sin_neg;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [55:0]        ph_sum;
    logic [PHASE_W-1:0] d24;
    logic [PHASE_W-1:0] ph_inc;
    logic [6:0]         dv;
    logic [31:0]        rem;
    logic [29:0]        q_fix;
    logic [SUM_W-1:0]   term_u;
    logic [SUM_W-1:0]   term_n;

    assign rate_bits = i_rate;
    assign rate_neg  = rate_bits[RATE_W-1];
    assign rate_mag  = rate_neg ? (~rate_bits + 16'd1) : rate_bits;

    // angle within its quadrant; second pass uses the complement
    assign u = i_cmd.pass ? (QUARTER - {1'b0, r_angle[21:0]}) : {1'b0, r_angle[21:0]};

    // quadrant folding
    assign cos_mag = r_angle[22] ? r_sin_r : r_sin_c;
    assign sin_mag = r_angle[22] ? r_sin_c : r_sin_r;
    assign cos_neg = r_angle[22] ^ r_angle[23];
    assign sin_neg = r_angle[23];

    assign dv = div_const(i_cmd.iter);

    always_comb begin
        case (i_cmd.op)
            OP_PH0: begin
                mul_a = {16'd0, rate_mag};
                mul_b = {16'd0, i_step};
            end
            OP_PH1: begin
                mul_a = {16'd0, r_p[15:0]};
                mul_b = {4'd0, PHASE_K};
            end
            OP_PH2: begin
                mul_a = {16'd0, r_p[31:16]};
                mul_b = {4'd0, PHASE_K};
            end
            OP_T_X: begin
                mul_a = {9'd0, u};
                mul_b = HALFPI_Q30;
            end
            OP_T_X2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            OP_T_M: begin
                mul_a = r_x2;
                mul_b = {1'b0, r_t};
            end
            OP_T_Q: begin
                mul_a = r_m;
                mul_b = recip_const(i_cmd.iter);
            end
            OP_T_C: begin
                mul_a = {2'd0, r_q0};
                mul_b = {25'd0, dv};
            end
            OP_T_S: begin
                mul_a = r_x;
                mul_b = {1'b0, r_t};
            end
            OP_TERM_X: begin
                mul_a = {16'd0, i_len};
                mul_b = {1'b0, cos_mag};
            end
            OP_TERM_Y: begin
                mul_a = {16'd0, i_len};
                mul_b = {1'b0, sin_mag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // phase increment, rounded half up on the magnitude
    assign ph_sum = 56'({r_hi, 16'd0}) + 56'(r_lo) + PH_ROUND;
    assign d24    = ph_sum[55:32];
    assign ph_inc = rate_neg ? (~d24 + 24'd1) : d24;

    // quotient estimate is low by at most one
    assign rem   = r_m - prod[31:0];
    assign q_fix = (rem >= {25'd0, dv}) ? (r_q0 + 30'd1) : r_q0;

    assign term_u = SUM_W'(prod[46:0]);
    assign term_n = ~term_u + SUM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.op == OP_PH3) begin
            r_phase <= r_phase + ph_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_PH0:    r_p     <= prod[31:0];
            OP_PH1:    r_lo    <= prod[43:0];
            OP_PH2:    r_hi    <= prod[43:0];
            OP_ANG:    r_angle <= i_angle + r_phase;
            OP_T_X: begin
                r_x <= prod[53:22];
                r_t <= ONE_Q30;
            end
            OP_T_X2:   r_x2 <= prod[61:30];
            OP_T_M:    r_m  <= prod[61:30];
            OP_T_Q:    r_q0 <= prod[61:32];
            OP_T_C:    r_t  <= ONE_Q30 - {1'b0, q_fix};
            OP_T_S: begin
                if (i_cmd.pass) begin
                    r_sin_c <= prod[60:30];
                end else begin
                    r_sin_r <= prod[60:30];
                end
            end
            OP_TERM_X: r_tx <= cos_neg ? term_n : term_u;
            OP_TERM_Y: r_ty <= sin_neg ? term_n : term_u;
            OP_SUM: begin
                r_sx <= i_sum_x + r_tx;
                r_sy <= i_sum_y + r_ty;
            end
            default: ;
        endcase
    end

    assign o_angle = r_angle;
    assign o_sum_x = r_sx;
    assign o_sum_y = r_sy;

endmodule

[rtl/ecpg_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer that steps all cells through one point computation.
module ecpg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_out_full,
    input  logic           i_out_take,
    output ecpg_pkg::t_cmd o_cmd,
    output logic           o_load
);
    import ecpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PH0,
        S_PH1,
        S_PH2,
        S_PH3,
        S_ANG,
        S_TX,
        S_TX2,
        S_TM,
        S_TQ,
        S_TC,
        S_TS,
        S_TERM_X,
        S_TERM_Y,
        S_SUM,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [ITER_W-1:0] r_iter;
    logic              r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_iter  <= '0;
            r_pass  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_PH0;
                S_PH0:  r_state <= S_PH1;
                S_PH1:  r_state <= S_PH2;
                S_PH2:  r_state <= S_PH3;
                S_PH3: begin
                    r_state <= S_ANG;
                    r_cnt   <= '0;
                end
                S_ANG: begin
                    if (r_cnt == CNT_W'(ARMS - 1)) begin
                        r_state <= S_TX;
                        r_pass  <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_TX: begin
                    r_state <= S_TX2;
                    r_iter  <= '0;
                end
                S_TX2: r_state <= S_TM;
                S_TM:  r_state <= S_TQ;
                S_TQ:  r_state <= S_TC;
                S_TC: begin
                    if (r_iter == ITER_W'(NUM_DIVS - 1)) begin
                        r_state <= S_TS;
                    end else begin
                        r_iter  <= r_iter + ITER_W'(1);
                        r_state <= S_TM;
                    end
                end
                S_TS: begin
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= S_TX;
                    end else begin
                        r_state <= S_TERM_X;
                    end
                end
                S_TERM_X: r_state <= S_TERM_Y;
                S_TERM_Y: begin
                    r_state <= S_SUM;
                    r_cnt   <= '0;
                end
                S_SUM: begin
                    if (r_cnt == CNT_W'(ARMS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_FIN: if (!i_out_full || i_out_take) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.iter = r_iter;
        o_cmd.pass = r_pass;
        case (r_state)
            S_PH0:    o_cmd.op = OP_PH0;
            S_PH1:    o_cmd.op = OP_PH1;
            S_PH2:    o_cmd.op = OP_PH2;
            S_PH3:    o_cmd.op = OP_PH3;
            S_ANG:    o_cmd.op = OP_ANG;
            S_TX:     o_cmd.op = OP_T_X;
            S_TX2:    o_cmd.op = OP_T_X2;
            S_TM:     o_cmd.op = OP_T_M;
            S_TQ:     o_cmd.op = OP_T_Q;
            S_TC:     o_cmd.op = OP_T_C;
            S_TS:     o_cmd.op = OP_T_S;
            S_TERM_X: o_cmd.op = OP_TERM_X;
            S_TERM_Y: o_cmd.op = OP_TERM_Y;
            S_SUM:    o_cmd.op = OP_SUM;
            default:  o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_load     = (r_state == S_FIN) && (!i_out_full || i_out_take);

endmodule

[rtl/epicycle_chain_point_generator_top.sv]
`timescale 1ns / 1ps
// Top level of the epicycle chain point generator.
//
// Each input beat carries a time step (unsigned Q0.16 s). The block advances the
// phase of every arm by rate * step, then walks the arm angles down the chain of
// cells (each cell adds its own phase to the running angle), evaluates cosine and
// sine of each arm's angle and sums length * (cos, sin) down the chain again. The
// tip comes out as x/y, signed Q2.16, rounded half away from zero and saturated.
// While a point is computed the input is stalled; most of the work is done by the
// sine engine in each cell: two 18-step polynomial passes on the cell's one
// multiplier. The result sits in an output register, so the next time step is
// taken as soon as the point is loaded, even if the output side is stalled.
// Configuration registers (two per arm: length, rate) are to be written through
// the plain write port by the user only while the block is idle; the block does
// not enforce this. Indexes past the last one are ignored.
module epicycle_chain_point_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ecpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ecpg_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ecpg_pkg::STEP_W-1:0]         i_time_step,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ecpg_pkg::POS_W-1:0]   o_x_position,
    output logic signed [ecpg_pkg::POS_W-1:0]   o_y_position
);
    import ecpg_pkg::*;

    logic [LEN_W-1:0]         arm_len   [ARMS];
    logic signed [RATE_W-1:0] arm_rate  [ARMS];
    logic [PHASE_W-1:0]       ang_chain [ARMS+1];
    logic signed [SUM_W-1:0]  sx_chain  [ARMS+1];
    logic signed [SUM_W-1:0]  sy_chain  [ARMS+1];

    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_x_pos;
    logic signed [POS_W-1:0]  r_y_pos;

    t_cmd cmd;
    logic load;
    logic out_take;
    logic in_accept;

    // Magnitude round to Q16, then clamp to the Q2.16 range.
    function automatic logic signed [POS_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic               neg;
        logic [SUM_W-1:0]   mag;
        logic [SUM_W-1:0]   rnd;
        logic [SUM_W-31:0]  q;
        logic signed [POS_W-1:0] res;
        neg = v[SUM_W-1];
        mag = neg ? (~v + SUM_W'(1)) : v;
        rnd = mag + POS_ROUND;
        q   = rnd[SUM_W-1:30];
        if (!neg) begin
            res = (q > (SUM_W-30)'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(q);
        end else begin
            res = (q > (SUM_W-30)'(POS_MIN_MAG)) ? -POS_W'(POS_MIN_MAG) : -POS_W'(q);
        end
        return res;
    endfunction

    // Per-arm configuration; arms without registers sit still at length zero.
    for (genvar k = 0; k < ARMS; k++) begin : g_cfg
        if (k < CFG_ARMS) begin : g_reg
            logic [LEN_W-1:0]         r_len;
            logic signed [RATE_W-1:0] r_rate;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_len  <= len_reset(k);
                    r_rate <= rate_reset(k);
                end else if (i_cfg_we) begin
                    if (i_cfg_idx == CFG_IDX_W'(2 * k + REG_LEN_OFS)) begin
                        r_len <= i_cfg_data;
                    end
                    if (i_cfg_idx == CFG_IDX_W'(2 * k + REG_RATE_OFS)) begin
                        r_rate <= i_cfg_data;
                    end
                end
            end
            assign arm_len[k]  = r_len;
            assign arm_rate[k] = r_rate;
        end else begin : g_none
            assign arm_len[k]  = '0;
            assign arm_rate[k] = '0;
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_step <= i_time_step;
        end
    end

    ecpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_full (r_out_valid),
        .i_out_take (out_take),
        .o_cmd      (cmd),
        .o_load     (load)
    );

    // Chain head: angle and sums start from zero.
    assign ang_chain[0] = '0;
    assign sx_chain[0]  = '0;
    assign sy_chain[0]  = '0;

    for (genvar k = 0; k < ARMS; k++) begin : g_arm
        ecpg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_step  (r_step),
            .i_len   (arm_len[k]),
            .i_rate  (arm_rate[k]),
            .i_angle (ang_chain[k]),
            .o_angle (ang_chain[k+1]),
            .i_sum_x (sx_chain[k]),
            .i_sum_y (sy_chain[k]),
            .o_sum_x (sx_chain[k+1]),
            .o_sum_y (sy_chain[k+1])
        );
    end

    // Output register: one beat per point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x_pos <= round_sat(sx_chain[ARMS]);
            r_y_pos <= round_sat(sy_chain[ARMS]);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_position = r_x_pos;
    assign o_y_position = r_y_pos;

endmodule

[rtl/ecpg_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the epicycle chain point generator, bound to the top.
module ecpg_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [ecpg_pkg::POS_W-1:0]   o_x_position,
    input logic signed [ecpg_pkg::POS_W-1:0]   o_y_position
);
    import ecpg_pkg::*;

    // a held output beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a held output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_x_position) && $stable(o_y_position))
        else $error("output payload changed while stalled");

    // a taken time step makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a beat was taken");

    // the block frees its input only by delivering a point
    a_done_has_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) && $past(i_rst_n) |-> o_out_valid)
        else $error("block went idle without a point");

endmodule

bind epicycle_chain_point_generator_top ecpg_chk u_ecpg_chk (.*);
